// File: design/npfl_pkg.sv
// ----------------------------------------------------------------------------
// npfl_pkg: shared types and constants of the nearest point field lookup
// Field widths, stream packing offsets, operation codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package npfl_pkg;

    // Default storage geometry
    localparam int POINTS_DEF     = 16384;
    localparam int COORD_BITS_DEF = 24;
    localparam int FIELD_BITS_DEF = 32;

    // Fixed field widths of the stream items
    localparam int IDX_W   = 14;
    localparam int CNT_W   = 15;
    localparam int CRD_W   = 24;
    localparam int FLD_W   = 32;
    localparam int DIST_W  = 50;

    // Input tdata: point_index, coord_x/y/z, field_x/y/z, low bits first
    localparam int IN_IDX_LO = 0;
    localparam int IN_CX_LO  = IN_IDX_LO + IDX_W;
    localparam int IN_CY_LO  = IN_CX_LO + CRD_W;
    localparam int IN_CZ_LO  = IN_CY_LO + CRD_W;
    localparam int IN_FX_LO  = IN_CZ_LO + CRD_W;
    localparam int IN_FY_LO  = IN_FX_LO + FLD_W;
    localparam int IN_FZ_LO  = IN_FY_LO + FLD_W;
    localparam int IN_USED_W = IN_FZ_LO + FLD_W;
    localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

    // Output tdata: nearest_index, near_field_x/y/z, best_dist_sq
    localparam int OUT_TDATA_W = ((IDX_W + 3 * FLD_W + DIST_W + 7) / 8) * 8;

    // Operation codes carried in s_axis_tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_DONE
    } npfl_state_t;

endpackage

`default_nettype wire

// File: design/nearest_point_field_lookup_unit.sv
// ----------------------------------------------------------------------------
// nearest_point_field_lookup_unit: brute-force 3D nearest point search
// Point table with attached field vectors, searched by squared distance.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one transaction per item: tuser is the op (write entry or
//   query), tdata the index, coordinates and field. m_axis returns exactly
//   one transaction per input item: the winning index, its field vector and
//   the squared distance; a write echoes its index with all other fields zero.
//   cfg_wr_en/cfg_wr_data load points_in_use (entries scanned from entry 0,
//   clamped to 1..POINTS); write it only while the block is idle.
//   Sequence: a write goes straight to the result step; a query scans the
//   entries, drains the pipeline and fetches the winner's field first. The
//   distance pipeline (coordinate memory read, absolute difference, three
//   squares, saturating sum, compare) handles one table entry per cycle.
//   s_axis_tready is high only while the sequencer is idle; one item is in
//   work at a time.
//   A finished result sits in the output register; if m_axis_tready is low
//   the result holds there while the next item may already be accepted,
//   and that item waits in its last step until the register frees up.
//   Reset clears the sequencer, the output valid and sets points_in_use to
//   1. Table contents are undefined until written; no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_point_field_lookup_unit
    import npfl_pkg::*;
#(
    parameter int POINTS     = POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FIELD_BITS = FIELD_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // point_index, coord_x, coord_y, coord_z, field_x, field_y, field_z
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // op
    input  wire logic                   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // nearest_index, near_field_x, near_field_y, near_field_z, best_dist_sq
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CNT_W-1:0]       cfg_wr_data
);

    localparam int AW   = $clog2(POINTS);
    localparam int CW   = $clog2(POINTS + 1);
    localparam int KW   = (CW > CNT_W) ? CW : CNT_W;
    localparam int XW   = (CW > IDX_W) ? CW : IDX_W;
    localparam int C    = COORD_BITS;
    localparam int F    = FIELD_BITS;
    localparam int SQW  = 2 * C;
    localparam int SUMW = 2 * C + 2;
    localparam int DW   = (SUMW > 64) ? 64 : SUMW;

    // ------------------------------------------------------------------
    // Sequencer and control registers
    // ------------------------------------------------------------------
    npfl_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   pin_reg;
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      scan_reg;
    logic               is_write_reg;
    logic [IDX_W-1:0]   wr_idx_reg;
    logic               out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic               in_acc;
    logic               scan_act;
    logic               scan_last;
    logic               load_out;
    logic               mem_we;
    logic               pipe_busy;

    // Input field slices
    logic [IDX_W-1:0]   in_idx;
    logic [C-1:0]       in_cx, in_cy, in_cz;
    logic [F-1:0]       in_fx, in_fy, in_fz;
    logic [XW-1:0]      widx;
    logic [AW-1:0]      waddr;
    logic [KW-1:0]      cnt_ext;
    logic [CW-1:0]      cnt_clamp;

    assign in_idx = s_axis_tdata[IN_IDX_LO +: IDX_W];
    assign in_cx  = C'(s_axis_tdata[IN_CX_LO +: CRD_W]);
    assign in_cy  = C'(s_axis_tdata[IN_CY_LO +: CRD_W]);
    assign in_cz  = C'(s_axis_tdata[IN_CZ_LO +: CRD_W]);
    assign in_fx  = F'(s_axis_tdata[IN_FX_LO +: FLD_W]);
    assign in_fy  = F'(s_axis_tdata[IN_FY_LO +: FLD_W]);
    assign in_fz  = F'(s_axis_tdata[IN_FZ_LO +: FLD_W]);
    assign widx   = XW'(in_idx);
    assign waddr  = widx[AW-1:0];

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign scan_last = ((CW'(scan_reg) + CW'(1)) == count_reg);

    // Clamp the entry count into 1..POINTS
    always_comb
    begin
        cnt_ext = KW'(pin_reg);
        if (cnt_ext == '0)
        begin
            cnt_clamp = CW'(1);
        end
        else if (cnt_ext > KW'(POINTS))
        begin
            cnt_clamp = CW'(POINTS);
        end
        else
        begin
            cnt_clamp = CW'(cnt_ext);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (s_axis_tuser == OP_QUERY) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        scan_act      = 1'b0;
        load_out      = 1'b0;
        mem_we        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                mem_we = s_axis_tvalid && (s_axis_tuser == OP_WRITE)
                         && (widx < XW'(POINTS));
            end
            ST_SCAN:
            begin
                scan_act = 1'b1;
            end
            ST_DONE:
            begin
                load_out = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pin_reg   <= CNT_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                pin_reg <= cfg_wr_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Table memories
    // ------------------------------------------------------------------
    logic [C-1:0] mem_cx [POINTS];
    logic [C-1:0] mem_cy [POINTS];
    logic [C-1:0] mem_cz [POINTS];
    logic [F-1:0] mem_fx [POINTS];
    logic [F-1:0] mem_fy [POINTS];
    logic [F-1:0] mem_fz [POINTS];

    logic [C-1:0] rd_cx, rd_cy, rd_cz;
    logic [F-1:0] rd_fx, rd_fy, rd_fz;
    logic [AW-1:0] best_idx_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_cx[waddr] <= in_cx;
            mem_cy[waddr] <= in_cy;
            mem_cz[waddr] <= in_cz;
        end
        rd_cx <= mem_cx[scan_reg];
        rd_cy <= mem_cy[scan_reg];
        rd_cz <= mem_cz[scan_reg];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_fx[waddr] <= in_fx;
            mem_fy[waddr] <= in_fy;
            mem_fz[waddr] <= in_fz;
        end
        rd_fx <= mem_fx[best_idx_reg];
        rd_fy <= mem_fy[best_idx_reg];
        rd_fz <= mem_fz[best_idx_reg];
    end

    // ------------------------------------------------------------------
    // Distance pipeline: read, abs diff, square, saturating sum, compare
    // ------------------------------------------------------------------
    logic [C-1:0]   qx_reg, qy_reg, qz_reg;
    logic [3:0]     pv_reg;
    logic [AW-1:0]  idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic [C-1:0]   ax_reg, ay_reg, az_reg;
    logic [SQW-1:0] sx_reg, sy_reg, sz_reg;
    logic [DW-1:0]  dist_reg;
    logic [DW-1:0]  best_reg;

    logic signed [C:0] dx, dy, dz;
    logic [C-1:0]   ax_next, ay_next, az_next;
    logic [SUMW-1:0] sum;
    logic [DW-1:0]  dist_next;

    assign pipe_busy = (pv_reg != '0);

    always_comb
    begin
        dx = $signed({rd_cx[C-1], rd_cx}) - $signed({qx_reg[C-1], qx_reg});
        dy = $signed({rd_cy[C-1], rd_cy}) - $signed({qy_reg[C-1], qy_reg});
        dz = $signed({rd_cz[C-1], rd_cz}) - $signed({qz_reg[C-1], qz_reg});
        ax_next = dx[C] ? C'(-dx) : C'(dx);
        ay_next = dy[C] ? C'(-dy) : C'(dy);
        az_next = dz[C] ? C'(-dz) : C'(dz);
        sum = SUMW'(sx_reg) + SUMW'(sy_reg) + SUMW'(sz_reg);
        // saturate at the 64-bit ceiling when the sum can exceed it
        dist_next = ((sum >> DW) != '0) ? '1 : DW'(sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
        end
        else
        begin
            pv_reg <= {pv_reg[2:0], scan_act};
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            qx_reg       <= in_cx;
            qy_reg       <= in_cy;
            qz_reg       <= in_cz;
            count_reg    <= cnt_clamp;
            is_write_reg <= (s_axis_tuser == OP_WRITE);
            wr_idx_reg   <= in_idx;
        end
        if (in_acc)
        begin
            scan_reg <= '0;
        end
        else if (scan_act && !scan_last)
        begin
            scan_reg <= scan_reg + AW'(1);
        end
        idx1_reg <= scan_reg;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        az_reg   <= az_next;
        idx2_reg <= idx1_reg;
        sx_reg   <= SQW'(ax_reg) * SQW'(ax_reg);
        sy_reg   <= SQW'(ay_reg) * SQW'(ay_reg);
        sz_reg   <= SQW'(az_reg) * SQW'(az_reg);
        idx3_reg <= idx2_reg;
        dist_reg <= dist_next;
        idx4_reg <= idx3_reg;
        // strict compare: the lowest index keeps a tie
        if (in_acc)
        begin
            best_reg     <= '1;
            best_idx_reg <= '0;
        end
        else if (pv_reg[3] && (dist_reg < best_reg))
        begin
            best_reg     <= dist_reg;
            best_idx_reg <= idx4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [63:0]        best64;
    logic signed [63:0] fx64, fy64, fz64;
    logic [OUT_TDATA_W-1:0] res_data;

    always_comb
    begin
        best64 = 64'(best_reg);
        fx64   = 64'(signed'(rd_fx));
        fy64   = 64'(signed'(rd_fy));
        fz64   = 64'(signed'(rd_fz));
        if (is_write_reg)
        begin
            res_data = OUT_TDATA_W'(wr_idx_reg);
        end
        else
        begin
            res_data = OUT_TDATA_W'({best64[DIST_W-1:0], fz64[FLD_W-1:0],
                                     fy64[FLD_W-1:0], fx64[FLD_W-1:0],
                                     IDX_W'(best_idx_reg)});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= res_data;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CW'(scan_reg) < count_reg))
        else $error("scan index reached the entry count");

    a_pipe_only_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_busy |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("distance pipeline busy outside a scan");

    a_winner_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !is_write_reg) |-> (CW'(best_idx_reg) < count_reg))
        else $error("winning index outside the scanned range");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start work");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> m_axis_tvalid)
        else $error("result loaded without raising valid");

endmodule

`default_nettype wire
